@@ sv/dtf_pkg.sv @@
// Types and constants for the dual temperature fusion check.
// Holds the sample and result item types, status codes and register indexes.
// No dependencies.
package dtf_pkg;

  typedef struct packed {
    logic [19:0]        bmp_raw;
    logic               bmp_ok;
    logic signed [15:0] ref_raw;
    logic               ref_ok;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] comp_temp;
    logic signed [15:0] ref_temp;
    logic signed [15:0] mean_temp;
    logic signed [15:0] weighted_temp;
    logic [15:0]        abs_difference;
    logic [15:0]        error_hundredths;
    logic [1:0]         status;
  } result_t;

  localparam logic [1:0] ST_NORMAL   = 2'd0;
  localparam logic [1:0] ST_WARNING  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FAIL     = 2'd3;

  localparam logic [2:0] REG_CAL_OFFSET     = 3'd0;
  localparam logic [2:0] REG_CAL_LINEAR     = 3'd1;
  localparam logic [2:0] REG_CAL_SQUARE     = 3'd2;
  localparam logic [2:0] REG_WARN_LIMIT     = 3'd3;
  localparam logic [2:0] REG_MISMATCH_LIMIT = 3'd4;

  localparam logic [15:0] WARN_LIMIT_RESET     = 16'd300;
  localparam logic [15:0] MISMATCH_LIMIT_RESET = 16'd500;

  // floor(n / 10) = (n * WT_RECIP) >> WT_SHIFT for n below 2^19
  localparam logic [19:0] WT_RECIP = 20'd838861;
  localparam int          WT_SHIFT = 23;

  localparam logic [13:0] ERR_SCALE = 14'd10000;
  localparam int          QUO_BITS  = 16;

endpackage

@@ sv/dual_temperature_fusion_check.sv @@
// Dual temperature fusion check, top level.
// Compensation, scaling, fusion and a pipelined restoring divider for the error.
// Depends on dtf_pkg.
//
//   channel   handshake          payload           width
//   sample    start / busy       sample (sample_t) 38
//   result    done (strobe)      result (result_t) 98
//   config    wr_en              wr_index, wr_data 3 + 16
//
// One item per cycle. The pipeline holds 9 arithmetic stages, the 16 one-bit
// stages of the error divider and the output register.
// rst is synchronous and clears the valid bits, done and the configuration
// registers to their reset values; the data registers are not reset.
// busy is high only while rst is high. The receiver cannot stall: the pipeline
// always advances and done marks each result for one cycle.
module dual_temperature_fusion_check
  import dtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  sample_t     sample,
  output logic        done,
  output result_t     result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data
);

  typedef struct packed {
    logic               ok;
    logic               zero;
    logic               sat;
    logic signed [15:0] comp_temp;
    logic signed [15:0] ref_temp;
    logic signed [15:0] mean_temp;
    logic signed [15:0] weighted_temp;
    logic [15:0]        abs_difference;
  } carry_t;

  logic [15:0]        cal_offset;
  logic signed [15:0] cal_linear;
  logic signed [15:0] cal_square;
  logic [15:0]        warn_limit;
  logic [15:0]        mismatch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset     <= '0;
      cal_linear     <= '0;
      cal_square     <= '0;
      warn_limit     <= WARN_LIMIT_RESET;
      mismatch_limit <= MISMATCH_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CAL_OFFSET:     cal_offset     <= wr_data;
        REG_CAL_LINEAR:     cal_linear     <= $signed(wr_data);
        REG_CAL_SQUARE:     cal_square     <= $signed(wr_data);
        REG_WARN_LIMIT:     warn_limit     <= wr_data;
        REG_MISMATCH_LIMIT: mismatch_limit <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // stage 1: offset terms and reference scaling
  logic signed [18:0] a_calc;
  logic signed [16:0] d_calc;
  logic signed [20:0] rx;
  logic signed [20:0] rr25;

  assign a_calc = $signed({2'b00, sample.bmp_raw[19:3]}) - $signed({2'b00, cal_offset, 1'b0});
  assign d_calc = $signed({1'b0, sample.bmp_raw[19:4]}) - $signed({1'b0, cal_offset});
  assign rx     = {{5{sample.ref_raw[15]}}, sample.ref_raw};
  assign rr25   = (rx <<< 4) + (rx <<< 3) + rx;

  logic               s1_valid, s1_ok;
  logic signed [18:0] s1_a;
  logic signed [16:0] s1_d;
  logic signed [15:0] s1_r;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
    s1_ok <= sample.bmp_ok && sample.ref_ok;
    s1_a  <= a_calc;
    s1_d  <= d_calc;
    s1_r  <= rr25[20:5];
  end

  // stage 2: linear product and square
  logic signed [34:0] p1_calc;
  logic signed [33:0] dd_calc;

  assign p1_calc = s1_a * cal_linear;
  assign dd_calc = s1_d * s1_d;

  logic               s2_valid, s2_ok;
  logic signed [34:0] s2_p1;
  logic [31:0]        s2_dd;
  logic signed [15:0] s2_r;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_ok <= s1_ok;
    s2_p1 <= p1_calc;
    s2_dd <= dd_calc[31:0];
    s2_r  <= s1_r;
  end

  // stage 3: quadratic product
  logic signed [36:0] p2_calc;

  assign p2_calc = $signed({1'b0, s2_dd[31:12]}) * cal_square;

  logic               s3_valid, s3_ok;
  logic signed [23:0] s3_x1;
  logic signed [36:0] s3_p2;
  logic signed [15:0] s3_r;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_ok <= s2_ok;
    s3_x1 <= s2_p1[34:11];
    s3_p2 <= p2_calc;
    s3_r  <= s2_r;
  end

  // stage 4: sum, scale by five and round
  logic signed [24:0] sum_calc;
  logic signed [27:0] sx;
  logic signed [27:0] t_calc;

  assign sum_calc = s3_x1 + $signed(s3_p2[36:14]);
  assign sx       = 28'(sum_calc);
  assign t_calc   = (sx <<< 2) + sx + 28'sd128;

  logic               s4_valid, s4_ok;
  logic signed [19:0] s4_t;
  logic signed [15:0] s4_r;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else     s4_valid <= s3_valid;
    s4_ok <= s3_ok;
    s4_t  <= t_calc[27:8];
    s4_r  <= s3_r;
  end

  // stage 5: saturate
  logic signed [15:0] b_calc;

  always_comb begin
    if (s4_t > 20'sd32767)       b_calc = 16'sh7FFF;
    else if (s4_t < -20'sd32768) b_calc = -16'sh8000;
    else                         b_calc = s4_t[15:0];
  end

  logic               s5_valid, s5_ok;
  logic signed [15:0] s5_b;
  logic signed [15:0] s5_r;

  always_ff @(posedge clk) begin
    if (rst) s5_valid <= 1'b0;
    else     s5_valid <= s4_valid;
    s5_ok <= s4_ok;
    s5_b  <= b_calc;
    s5_r  <= s4_r;
  end

  // stage 6: difference, mean, weighted sum
  logic signed [16:0] bx, rxx;
  logic signed [16:0] msum;
  logic signed [20:0] bw, rw;

  assign bx   = 17'(s5_b);
  assign rxx  = 17'(s5_r);
  assign msum = bx + rxx;
  assign bw   = 21'(s5_b);
  assign rw   = 21'(s5_r);

  logic               s6_valid, s6_ok;
  logic signed [15:0] s6_b, s6_r, s6_mean;
  logic signed [16:0] s6_diff;
  logic signed [20:0] s6_wsum;

  always_ff @(posedge clk) begin
    if (rst) s6_valid <= 1'b0;
    else     s6_valid <= s5_valid;
    s6_ok   <= s5_ok;
    s6_b    <= s5_b;
    s6_r    <= s5_r;
    s6_mean <= msum[16:1];
    s6_diff <= bx - rxx;
    s6_wsum <= (bw <<< 1) + bw + (rw <<< 3) - rw;
  end

  // stage 7: magnitudes
  function automatic logic signed [20:0] rw_ext(input logic signed [15:0] v);
    return 21'(v);
  endfunction

  logic [16:0] diff_mag;
  logic [20:0] r_mag;
  logic [20:0] w_mag;

  assign diff_mag = s6_diff[16] ? 17'(-s6_diff) : 17'(s6_diff);
  assign r_mag    = s6_r[15] ? 21'(-rw_ext(s6_r)) : 21'(rw_ext(s6_r));
  assign w_mag    = s6_wsum[20] ? 21'(-s6_wsum) : 21'(s6_wsum);

  logic               s7_valid, s7_ok, s7_wneg;
  logic signed [15:0] s7_b, s7_r, s7_mean;
  logic [15:0]        s7_diff;
  logic [14:0]        s7_ar;
  logic [18:0]        s7_wmag;

  always_ff @(posedge clk) begin
    if (rst) s7_valid <= 1'b0;
    else     s7_valid <= s6_valid;
    s7_ok   <= s6_ok;
    s7_b    <= s6_b;
    s7_r    <= s6_r;
    s7_mean <= s6_mean;
    s7_diff <= diff_mag[15:0];
    s7_ar   <= r_mag[14:0];
    s7_wmag <= w_mag[18:0];
    s7_wneg <= s6_wsum[20];
  end

  // stage 8: divide weighted sum by ten, scale error numerator
  logic [38:0] wprod_calc;
  logic [29:0] num_calc;

  assign wprod_calc = {20'd0, s7_wmag} * {19'd0, WT_RECIP};
  assign num_calc   = {14'd0, s7_diff} * {16'd0, ERR_SCALE};

  logic               s8_valid, s8_ok, s8_wneg;
  logic signed [15:0] s8_b, s8_r, s8_mean;
  logic [15:0]        s8_diff;
  logic [14:0]        s8_ar;
  logic [38:0]        s8_wprod;
  logic [29:0]        s8_num;

  always_ff @(posedge clk) begin
    if (rst) s8_valid <= 1'b0;
    else     s8_valid <= s7_valid;
    s8_ok    <= s7_ok;
    s8_b     <= s7_b;
    s8_r     <= s7_r;
    s8_mean  <= s7_mean;
    s8_diff  <= s7_diff;
    s8_ar    <= s7_ar;
    s8_wneg  <= s7_wneg;
    s8_wprod <= wprod_calc;
    s8_num   <= num_calc;
  end

  // stage 9: sign of weighted mean, divider entry
  logic [15:0] wq;
  carry_t      c9;

  assign wq = s8_wprod[WT_SHIFT +: 16];

  always_comb begin
    c9.ok             = s8_ok;
    c9.zero           = (s8_ar == 15'd0);
    c9.sat            = {1'b0, s8_num} >= {s8_ar, 16'd0};
    c9.comp_temp      = s8_b;
    c9.ref_temp       = s8_r;
    c9.mean_temp      = s8_mean;
    c9.weighted_temp  = s8_wneg ? $signed(-wq) : $signed(wq);
    c9.abs_difference = s8_diff;
  end

  logic              dv_valid [QUO_BITS+1];
  carry_t            dv_carry [QUO_BITS+1];
  logic [29:0]       dv_rem   [QUO_BITS+1];
  logic [14:0]       dv_dsr   [QUO_BITS+1];
  logic [QUO_BITS-1:0] dv_quo [QUO_BITS+1];

  // restoring division, one quotient bit per stage, MSB first
  logic [30:0] dv_shift [QUO_BITS];
  logic        dv_ge    [QUO_BITS];

  always_comb begin
    for (int k = 0; k < QUO_BITS; k++) begin
      dv_shift[k] = {16'd0, dv_dsr[k]} << (QUO_BITS - 1 - k);
      dv_ge[k]    = {1'b0, dv_rem[k]} >= dv_shift[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else     dv_valid[0] <= s8_valid;
    dv_carry[0] <= c9;
    dv_rem[0]   <= s8_num;
    dv_dsr[0]   <= s8_ar;
    dv_quo[0]   <= '0;
    for (int k = 0; k < QUO_BITS; k++) begin
      if (rst) dv_valid[k+1] <= 1'b0;
      else     dv_valid[k+1] <= dv_valid[k];
      dv_carry[k+1] <= dv_carry[k];
      dv_dsr[k+1]   <= dv_dsr[k];
      dv_rem[k+1]   <= dv_ge[k] ? dv_rem[k] - dv_shift[k][29:0] : dv_rem[k];
      dv_quo[k+1]   <= {dv_quo[k][QUO_BITS-2:0], dv_ge[k]};
    end
  end

  // output stage: saturate error, classify
  carry_t      cf;
  logic [15:0] err;
  result_t     res_next;

  assign cf  = dv_carry[QUO_BITS];
  assign err = (cf.zero || cf.sat) ? 16'hFFFF : dv_quo[QUO_BITS];

  always_comb begin
    res_next = '0;
    if (!cf.ok) begin
      res_next.status = ST_FAIL;
    end else begin
      res_next.comp_temp        = cf.comp_temp;
      res_next.ref_temp         = cf.ref_temp;
      res_next.mean_temp        = cf.mean_temp;
      res_next.weighted_temp    = cf.weighted_temp;
      res_next.abs_difference   = cf.abs_difference;
      res_next.error_hundredths = err;
      if (cf.zero || err >= mismatch_limit) res_next.status = ST_MISMATCH;
      else if (err >= warn_limit)           res_next.status = ST_WARNING;
      else                                  res_next.status = ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_valid[QUO_BITS];
    result <= res_next;
  end

endmodule
